// ----- rtl/interval_three_way_split_assert.svh -----
// assertion macros for the interval three-way split block
`ifndef INTERVAL_THREE_WAY_SPLIT_ASSERT_SVH
`define INTERVAL_THREE_WAY_SPLIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ITS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ITS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ITS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ITS_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/its_pkg.sv -----
// shared types and constants for the interval three-way split block
`default_nettype none
package its_pkg;
   localparam int COORD_W = 32;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;
   localparam int SIDE_W  = 2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;

   localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_CENTER = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd2;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SWEEP_INIT,
      ST_SWEEP,
      ST_LABEL_INIT,
      ST_LABEL,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;        // store one box
      logic sort_start;  // reset sort pass counters
      logic sort_read;   // read pair at sort index
      logic sort_step;   // compare and maybe swap, advance
      logic sweep_init;
      logic sweep_step;
      logic label_init;
      logic label_step;
      logic emit_read;
      logic emit_next;
   } cmd_type;

   typedef struct packed {
      logic sort_done;
      logic sweep_done;
      logic label_done;
      logic emit_last;
   } status_type;
endpackage
`default_nettype wire

// ----- rtl/its_channel_if.sv -----
// valid/ready channel interfaces for the input boxes and result labels
`default_nettype none
interface its_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] low_x;
   logic [31:0] low_y;
   logic [31:0] low_z;
   logic [31:0] high_x;
   logic [31:0] high_y;
   logic [31:0] high_z;
   logic        last_box;
   modport source (output valid, low_x, low_y, low_z, high_x, high_y, high_z, last_box,
                   input ready);
   modport sink (input valid, low_x, low_y, low_z, high_x, high_y, high_z, last_box,
                 output ready);
endinterface

interface its_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] box_index;
   logic [1:0] side;
   logic [6:0] left_count;
   logic [6:0] center_count;
   logic [6:0] right_count;
   logic       last_label;
   modport source (output valid, box_index, side, left_count, center_count, right_count,
                   last_label, input ready);
   modport sink (input valid, box_index, side, left_count, center_count, right_count,
                 last_label, output ready);
endinterface

interface its_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/its_datapath.sv -----
// endpoint memory, odd-even sort, sweep, labeling and output register
`default_nettype none
module its_datapath import its_pkg::*; #(
   parameter int MAX_BOXES = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [COORD_W-1:0]    lo_coord,
   input  wire logic [COORD_W-1:0]    hi_coord,
   output logic [IDX_W-1:0]           out_index,
   output logic [SIDE_W-1:0]          out_side,
   output logic [CNT_W-1:0]           out_left,
   output logic [CNT_W-1:0]           out_center,
   output logic [CNT_W-1:0]           out_right,
   output logic                       out_last
);
   localparam int NE  = 2 * MAX_BOXES;
   localparam int EW  = $clog2(NE);
   localparam int BW  = $clog2(MAX_BOXES);
   localparam int KW  = COORD_W + 1 + IDX_W;
   localparam int PW  = 19;

   // endpoint store, one key per entry: flipped coord, high flag, owner
   logic [KW-1:0] ep_mem [NE];
   logic [SIDE_W-1:0] side_mem [MAX_BOXES];

   logic [CNT_W-1:0] box_count_ff, box_count_in;
   logic [CNT_W:0]   n2;
   // sort: odd-even transposition, 2N passes over pairs for N boxes
   logic [CNT_W:0]   pass_ff, pass_in;
   logic [CNT_W:0]   pos_ff, pos_in;
   logic [KW-1:0]    ka_ff, kb_ff;
   logic [CNT_W:0]   sw_ff, sw_in;
   logic [KW-1:0]    rd_ff;
   logic [CNT_W-1:0] l_ff, c_ff, r_ff;
   logic [CNT_W-1:0] bl_ff, bc_ff, br_ff;
   logic [PW-1:0]    best_ff;
   logic [CNT_W-1:0] untouched_ff, passed_ff;
   logic [CNT_W-1:0] emit_ff;
   logic             sweep_rd_ok_ff;

   assign n2 = {box_count_ff, 1'b0};

   // pair at pos: a = pos, b = pos+1
   logic [CNT_W:0] pos_b;
   assign pos_b = pos_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.load && box_count_ff < CNT_W'(MAX_BOXES)) begin
         ep_mem[EW'({box_count_ff, 1'b0})] <=
            {lo_coord ^ 32'h8000_0000, 1'b0, box_count_ff[IDX_W-1:0]};
         ep_mem[EW'({box_count_ff, 1'b1})] <=
            {hi_coord ^ 32'h8000_0000, 1'b1, box_count_ff[IDX_W-1:0]};
      end
      // two read ports: the sort pair, or the sweep/label index on port a
      if (cmd.sort_read) begin
         ka_ff <= ep_mem[EW'(pos_ff)];
         kb_ff <= ep_mem[EW'(pos_b)];
      end else begin
         rd_ff <= ep_mem[EW'(sw_ff)];
      end
      if (cmd.sort_step && ka_ff > kb_ff) begin
         ep_mem[EW'(pos_ff)] <= kb_ff;
         ep_mem[EW'(pos_b)]  <= ka_ff;
      end
   end

   // sort position control
   always_comb begin
      pass_in = pass_ff;
      pos_in  = pos_ff;
      if (cmd.sort_start) begin
         pass_in = '0;
         pos_in  = '0;
      end else if (cmd.sort_step) begin
         if (pos_ff + 2'd3 < n2) begin
            pos_in = pos_ff + 2'd2;
         end else begin
            pass_in = pass_ff + 1'b1;
            pos_in  = {{CNT_W{1'b0}}, ~pass_ff[0]};
         end
      end
   end
   // a pass with no valid pair (odd pass on two endpoints) ends the sort
   assign status.sort_done = (pass_ff >= n2) || (pos_b >= n2 && !cmd.sort_start);

   // factor for the product of the counts: the count, or one below two
   function automatic logic [PW-1:0] fac(input logic [CNT_W-1:0] v);
      fac = (v > 1) ? PW'(v) : PW'(1);
   endfunction

   logic [CNT_W-1:0] nl, nc, nr;
   logic [2*CNT_W-1:0] plc;
   logic [2*CNT_W-1:0] plc_ff;
   logic [CNT_W-1:0] pl_ff, pc_ff, pr_ff;
   logic prod_v_ff;
   logic [1+IDX_W-1:0] rd_tail;
   assign rd_tail = rd_ff[IDX_W:0];

   always_comb begin
      nl = l_ff; nc = c_ff; nr = r_ff;
      if (!rd_tail[IDX_W]) begin
         nc = c_ff + 1'b1;
         if (r_ff != 0) nr = r_ff - 1'b1;
      end else begin
         if (c_ff != 0) nc = c_ff - 1'b1;
         nl = l_ff + 1'b1;
      end
   end
   assign plc = CNT_W'(fac(nl)) * CNT_W'(fac(nc));

   logic [PW-1:0] prod_comb;
   logic [2*CNT_W+CNT_W-1:0] full_prod;
   assign full_prod = plc_ff * CNT_W'(fac(pr_ff));
   assign prod_comb = full_prod[PW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         box_count_ff <= '0;
         pass_ff <= '0;
         pos_ff <= '0;
         sw_ff <= '0;
         emit_ff <= '0;
      end else begin
         box_count_ff <= box_count_in;
         if (cmd.sort_start || cmd.sort_step) begin
            pass_ff <= pass_in;
            pos_ff  <= pos_in;
         end
         sw_ff <= sw_in;
         if (cmd.emit_read) begin
            emit_ff <= emit_ff + 1'b1;
         end else if (cmd.label_init) begin
            emit_ff <= '0;
         end
      end
      if (cmd.sweep_init) begin
         l_ff <= '0; c_ff <= '0; r_ff <= box_count_ff;
         bl_ff <= '0; bc_ff <= '0; br_ff <= box_count_ff;
         best_ff <= fac(box_count_ff);
         prod_v_ff <= 1'b0;
         sweep_rd_ok_ff <= 1'b0;
      end else if (cmd.sweep_step) begin
         sweep_rd_ok_ff <= ~sweep_rd_ok_ff;
         prod_v_ff <= sweep_rd_ok_ff;
         if (sweep_rd_ok_ff) begin
            l_ff <= nl; c_ff <= nc; r_ff <= nr;
            pl_ff <= nl; pc_ff <= nc; pr_ff <= nr;
            plc_ff <= plc;
         end
         if (prod_v_ff && prod_comb > best_ff) begin
            best_ff <= prod_comb;
            bl_ff <= pl_ff; bc_ff <= pc_ff; br_ff <= pr_ff;
         end
      end
      if (cmd.label_init) begin
         untouched_ff <= box_count_ff;
         passed_ff <= '0;
         sweep_rd_ok_ff <= 1'b0;
      end else if (cmd.label_step) begin
         sweep_rd_ok_ff <= ~sweep_rd_ok_ff;
         if (sweep_rd_ok_ff) begin
            if (!rd_tail[IDX_W]) begin
               if ((untouched_ff - (untouched_ff != 0 ? 1'b1 : 1'b0)) < br_ff)
                  side_mem[BW'(rd_tail[IDX_W-1:0])] <= SIDE_RIGHT;
               else
                  side_mem[BW'(rd_tail[IDX_W-1:0])] <= SIDE_CENTER;
               if (untouched_ff != 0) untouched_ff <= untouched_ff - 1'b1;
            end else begin
               passed_ff <= passed_ff + 1'b1;
               if (passed_ff + 1'b1 <= bl_ff)
                  side_mem[BW'(rd_tail[IDX_W-1:0])] <= SIDE_LEFT;
            end
         end
      end
      if (cmd.emit_read) begin
         out_side   <= side_mem[BW'(emit_ff)];
         out_index  <= emit_ff[IDX_W-1:0];
         out_left   <= bl_ff;
         out_center <= bc_ff;
         out_right  <= br_ff;
         out_last   <= (emit_ff + 1'b1 == box_count_ff);
      end
   end

   // shared endpoint read index, advanced on steps whose read data is in use
   always_comb begin
      sw_in = sw_ff;
      if (cmd.sweep_init || cmd.label_init)
         sw_in = '0;
      else if ((cmd.sweep_step || cmd.label_step) && sweep_rd_ok_ff)
         sw_in = sw_ff + 1'b1;
   end

   always_comb begin
      box_count_in = box_count_ff;
      if (cmd.load && box_count_ff < CNT_W'(MAX_BOXES))
         box_count_in = box_count_ff + 1'b1;
      if (cmd.emit_next && out_last)
         box_count_in = '0;
   end

   // sweep ends once the last endpoint has gone through the compare stage
   assign status.sweep_done = (sw_ff == n2) && !prod_v_ff;
   assign status.label_done = (sw_ff == n2) && !sweep_rd_ok_ff;
   assign status.emit_last  = out_last;
endmodule
`default_nettype wire

// ----- rtl/its_ctrl.sv -----
// sequencer for load, sort, sweep, label and emit phases
`default_nettype none
module its_ctrl import its_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_fire,
   input  wire logic       req_last,
   input  wire logic       rsp_take,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            req_ready,
   output logic            rsp_valid
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:       if (req_fire && req_last) state_in = ST_SORT_RD;
         ST_SORT_RD:    state_in = status.sort_done ? ST_SWEEP_INIT : ST_SORT_CMP;
         ST_SORT_CMP:   state_in = ST_SORT_RD;
         ST_SWEEP_INIT: state_in = ST_SWEEP;
         ST_SWEEP:      if (status.sweep_done) state_in = ST_LABEL_INIT;
         ST_LABEL_INIT: state_in = ST_LABEL;
         ST_LABEL:      if (status.label_done) state_in = ST_EMIT_RD;
         ST_EMIT_RD:    state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_take) state_in = status.emit_last ? ST_LOAD : ST_EMIT_RD;
         end
         default:       state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load = req_fire;
            cmd.sort_start = req_fire && req_last;
         end
         ST_SORT_RD:    cmd.sort_read = !status.sort_done;
         ST_SORT_CMP:   cmd.sort_step = 1'b1;
         ST_SWEEP_INIT: cmd.sweep_init = 1'b1;
         ST_SWEEP:      cmd.sweep_step = !status.sweep_done;
         ST_LABEL_INIT: cmd.label_init = 1'b1;
         ST_LABEL:      cmd.label_step = !status.label_done;
         ST_EMIT_RD:    cmd.emit_read = 1'b1;
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.emit_next = rsp_take;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/interval_three_way_split.sv -----
// top level of the interval three-way split block
// usage:
// - req carries one box per transaction; last_box ends the set and starts a split
// - boxes load at one per cycle, up to MAX_BOXES; further boxes are dropped
// - after the last box req_ready stays low while the block sorts, sweeps and labels
// - sort is odd-even transposition over the endpoint store: 2N passes, each
//   pair handled in a read state and then a compare/swap state
// - sweep and label passes each take a read step and an update step per endpoint
// - rsp then carries N labels in box order; the next is read only after one is taken
// - csr writes the split axis (x, y, z; code 3 acts as z); always ready
// - reset returns to loading with an empty set
// - a stalled rsp holds its label in the output register until taken
`default_nettype none
`include "interval_three_way_split_assert.svh"
module interval_three_way_split import its_pkg::*; #(
   parameter int MAX_BOXES = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   its_req_if.sink   req,
   its_rsp_if.source rsp,
   its_csr_if.sink   csr
);
   logic [1:0] axis_ff;
   cmd_type    cmd;
   status_type status;
   logic       req_fire, rsp_take;
   logic [COORD_W-1:0] lo_sel, hi_sel, lo_ord, hi_ord;

   // axis register
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= AXIS_X;
      end else if (csr.valid) begin
         axis_ff <= csr.data;
      end
   end

   // pick the split axis and order the pair by signed value
   always_comb begin
      case (axis_ff)
         AXIS_X:  begin lo_sel = req.low_x; hi_sel = req.high_x; end
         AXIS_Y:  begin lo_sel = req.low_y; hi_sel = req.high_y; end
         default: begin lo_sel = req.low_z; hi_sel = req.high_z; end
      endcase
      if ($signed(lo_sel) > $signed(hi_sel)) begin
         lo_ord = hi_sel; hi_ord = lo_sel;
      end else begin
         lo_ord = lo_sel; hi_ord = hi_sel;
      end
   end

   assign req_fire = req.valid && req.ready;
   assign rsp_take = rsp.valid && rsp.ready;

   its_ctrl u_ctrl (
      .clock, .reset, .req_fire, .req_last(req.last_box), .rsp_take, .status,
      .cmd, .req_ready(req.ready), .rsp_valid(rsp.valid)
   );

   its_datapath #(.MAX_BOXES(MAX_BOXES)) u_dp (
      .clock, .reset, .cmd, .status, .lo_coord(lo_ord), .hi_coord(hi_ord),
      .out_index(rsp.box_index), .out_side(rsp.side), .out_left(rsp.left_count),
      .out_center(rsp.center_count), .out_right(rsp.right_count),
      .out_last(rsp.last_label)
   );

   // no box is taken while labels are pending
   `ITS_ASSERT_IMP(a_no_overlap, clock, reset, rsp.valid, !req.ready, "req ready while emitting")
   // a stalled label stays on the port
   `ITS_ASSERT_NXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.box_index), "label dropped")
   // after the final label the block loads again
   `ITS_ASSERT_NXT(a_reload, clock, reset, rsp_take && rsp.last_label, req.ready, "no reload after run")
endmodule
`default_nettype wire

// ----- tb/its_tb_pkg.sv -----
// shared constants for the interval three-way split testbench
`timescale 1ns / 100ps
package its_tb_pkg;
   localparam int TB_MAX_BOXES = 64;
   localparam logic [1:0] AXIS_Z     = 2'd2;
   localparam logic [1:0] AXIS_Z_ALT = 2'd3;
endpackage

// ----- tb/testbench.sv -----
// self-checking testbench for interval_three_way_split: directed table, random sets, predictor
`timescale 1ns / 100ps
module testbench;
   import its_pkg::*;
   import its_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   its_req_if req ();
   its_rsp_if rsp ();
   its_csr_if csr ();

   interval_three_way_split #(.MAX_BOXES(TB_MAX_BOXES)) u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   // one expected label
   typedef struct packed {
      logic [IDX_W-1:0]  box_index;
      logic [SIDE_W-1:0] side;
      logic [CNT_W-1:0]  left_count;
      logic [CNT_W-1:0]  center_count;
      logic [CNT_W-1:0]  right_count;
      logic              last_label;
   } label_type;

   // one box as it enters the block
   typedef struct {
      logic [COORD_W-1:0] lo [3];
      logic [COORD_W-1:0] hi [3];
      logic               last_box;
   } box_type;

   label_type expected_labels[$];
   int        mismatches = 0;

   // predictor state: endpoints of the current set on the split axis
   logic [1:0]         axis_sel = AXIS_X;
   logic signed [31:0] set_lo[TB_MAX_BOXES];
   logic signed [31:0] set_hi[TB_MAX_BOXES];
   int                 set_size = 0;

   function automatic int weight(int l, int c, int r);
      int p;
      p = 1;
      if (l > 1) p *= l;
      if (c > 1) p *= c;
      if (r > 1) p *= r;
      return p;
   endfunction

   // sort key: value, low before high, owner
   function automatic logic [38:0] ep_key(logic signed [31:0] v, logic is_hi, int own);
      return {v ^ 32'h8000_0000, is_hi, own[5:0]};
   endfunction

   // predicts the labels of one box; queues them when it closes a set
   task automatic predict_split(input box_type b);
      int                 ax, n, l, c, r, bl, bc, br, best, w, untouched, passed;
      logic signed [31:0] lo, hi, tmp;
      logic [38:0]        keys[$];
      logic [1:0]         sides[TB_MAX_BOXES];
      label_type          lab;
      ax = (axis_sel == AXIS_Z_ALT) ? 2 : int'(axis_sel);
      lo = b.lo[ax];
      hi = b.hi[ax];
      if (lo > hi) begin
         tmp = lo; lo = hi; hi = tmp;
      end
      // a full set drops the box
      if (set_size < TB_MAX_BOXES) begin
         set_lo[set_size] = lo;
         set_hi[set_size] = hi;
         set_size++;
      end
      if (!b.last_box) return;
      n = set_size;
      for (int i = 0; i < n; i++) begin
         keys.insert(keys.size(), ep_key(set_lo[i], 1'b0, i));
         keys.insert(keys.size(), ep_key(set_hi[i], 1'b1, i));
      end
      keys.sort();
      l = 0; c = 0; r = n; bl = 0; bc = 0; br = n;
      best = weight(l, c, r);
      foreach (keys[i]) begin
         if (!keys[i][6]) begin
            c++;
            if (r > 0) r--;
         end else begin
            if (c > 0) c--;
            l++;
         end
         w = weight(l, c, r);
         if (w > best) begin
            best = w; bl = l; bc = c; br = r;
         end
      end
      for (int i = 0; i < n; i++) sides[i] = SIDE_CENTER;
      untouched = n;
      passed = 0;
      foreach (keys[i]) begin
         if (!keys[i][6]) begin
            if (untouched > 0) untouched--;
            if (untouched < br) sides[keys[i][5:0]] = SIDE_RIGHT;
         end else begin
            passed++;
            if (passed <= bl) sides[keys[i][5:0]] = SIDE_LEFT;
         end
      end
      for (int i = 0; i < n; i++) begin
         lab.box_index    = i[IDX_W-1:0];
         lab.side         = sides[i];
         lab.left_count   = bl[CNT_W-1:0];
         lab.center_count = bc[CNT_W-1:0];
         lab.right_count  = br[CNT_W-1:0];
         lab.last_label   = (i == n - 1);
         expected_labels.insert(expected_labels.size(), lab);
      end
      set_size = 0;
   endtask

   // random gap length, mostly short, sometimes long
   function automatic int gap_len();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sends one box and predicts it; valid stays high into a back-to-back box
   task automatic send_box(input box_type b);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.low_x    <= b.lo[0];
      req.low_y    <= b.lo[1];
      req.low_z    <= b.lo[2];
      req.high_x   <= b.hi[0];
      req.high_y   <= b.hi[1];
      req.high_z   <= b.hi[2];
      req.last_box <= b.last_box;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_split(b);
   endtask

   // idles the sender until the split is drained, then a quiet spell
   task automatic drain_labels();
      req.valid <= 1'b0;
      while (expected_labels.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_axis(input logic [1:0] ax);
      csr.valid <= 1'b1;
      csr.data  <= ax;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      axis_sel = ax;
   endtask

   function automatic logic [31:0] rand_coord();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 32'h8000_0000;
      if (sel == 1) return 32'h7fff_ffff;
      if (sel < 6) return $urandom_range(0, 15) << 16;
      return $urandom();
   endfunction

   function automatic box_type rand_box(input logic is_last);
      box_type b;
      for (int k = 0; k < 3; k++) begin
         b.lo[k] = rand_coord();
         b.hi[k] = rand_coord();
      end
      b.last_box = is_last;
      return b;
   endfunction

   function automatic box_type mk_box(input logic [31:0] lo, input logic [31:0] hi,
                                      input logic is_last);
      box_type b;
      for (int k = 0; k < 3; k++) begin
         b.lo[k] = lo;
         b.hi[k] = hi;
      end
      b.last_box = is_last;
      return b;
   endfunction

   // result checker, with random back-pressure
   initial begin
      label_type got, want;
      int        stall;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = gap_len();
         rsp.ready <= (stall == 0);
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.box_index, rsp.side, rsp.left_count, rsp.center_count,
                    rsp.right_count, rsp.last_label};
            if (expected_labels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected label transaction %p", got);
            end else begin
               want = expected_labels.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("label mismatch: expected %p actual %p",
                                                 want, got);
               end
            end
         end
      end
   end

   // directed table: a box per row
   typedef struct {
      logic [31:0] lo;
      logic [31:0] hi;
      logic        last;
   } row_type;

   initial begin
      row_type   rows[$];
      int        set_len;
      label_type lab;
      req.valid = 1'b0; req.last_box = 1'b0;
      req.low_x = '0; req.low_y = '0; req.low_z = '0;
      req.high_x = '0; req.high_y = '0; req.high_z = '0;
      csr.valid = 1'b0; csr.data = AXIS_X;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a lone box: never beats the start position, so right with counts 0/0/1
      send_box(mk_box(32'h8000_0000, 32'h7fff_ffff, 1'b1));
      lab = expected_labels[0];
      if (lab.side != SIDE_RIGHT || lab.left_count != 0 || lab.center_count != 0 ||
          lab.right_count != 1) begin
         mismatches++;
         $display("predictor disagrees on lone box: expected right 0/0/1 actual %p", lab);
      end
      drain_labels();

      // extremes, inverted boxes, ties on value
      rows = '{'{32'h8000_0000, 32'h8000_0000, 1'b0}, '{32'h7fff_ffff, 32'h8000_0000, 1'b0},
               '{32'h0001_0000, 32'h0000_0000, 1'b0}, '{32'h0000_0000, 32'h0001_0000, 1'b0},
               '{32'h7fff_ffff, 32'h7fff_ffff, 1'b0}, '{32'h0005_0000, 32'h0006_0000, 1'b0},
               '{32'hffff_ffff, 32'h0000_0001, 1'b1},
               '{32'h0000_0000, 32'h0001_0000, 1'b0}, '{32'h0002_0000, 32'h0003_0000, 1'b0},
               '{32'h0004_0000, 32'h0005_0000, 1'b1}};
      foreach (rows[i]) send_box(mk_box(rows[i].lo, rows[i].hi, rows[i].last));
      drain_labels();

      // each axis with distinct per-axis content, axis code 3 acts as z
      for (int a = 0; a < 4; a++) begin
         write_axis(a[1:0]);
         for (int i = 0; i < 3; i++) send_box(rand_box(i == 2));
         drain_labels();
      end

      // overflow: 66 boxes, the last two dropped, the last one closes the set
      write_axis(AXIS_Y);
      for (int i = 0; i < 66; i++) send_box(rand_box(i == 65));
      drain_labels();

      // random sets, mostly small
      for (int s = 0; s < 24; s++) begin
         if (s % 10 == 5) begin
            drain_labels();
            write_axis(2'($urandom_range(0, 3)));
         end
         set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                                  : $urandom_range(1, 6);
         for (int i = 0; i < set_len; i++) send_box(rand_box(i == set_len - 1));
      end
      drain_labels();
      write_axis(AXIS_X);

      if (mismatches == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
